// ===== hdl/pcse_pkg.sv =====
package pcse_pkg;

  // Number of spline intervals and the wrap step limit.
  localparam int unsigned INTERVALS = 10;
  localparam int unsigned MAX_WRAPS = 16;

  localparam int unsigned NKNOTS = INTERVALS + 1;
  localparam int unsigned IDX_W  = $clog2(NKNOTS);
  localparam int unsigned WRAP_W = $clog2(MAX_WRAPS + 1);

  // The divider retires two quotient bits per cycle over a 64-bit dividend.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] TBL_KNOT = 2'd0;
  localparam logic [1:0] TBL_NODE = 2'd1;
  localparam logic [1:0] TBL_COEF = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         table_select;
    logic [3:0]         entry_index;
    logic signed [31:0] value_in;
  } pcse_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               range_fault;
    logic               divide_fault;
  } pcse_out_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic signed [31:0] divisor;
  } pcse_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quotient;
  } pcse_div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_GOT_LAST,
    ST_WRAP_HI,
    ST_WRAP_LO,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FIX,
    ST_RD0,
    ST_RD1,
    ST_RD1_WAIT,
    ST_TDX,
    ST_MUL_S,
    ST_DIV_A,
    ST_WAIT_A,
    ST_MUL_C,
    ST_DIV_E,
    ST_WAIT_E,
    ST_MUL_G,
    ST_CALC_H,
    ST_MUL_H,
    ST_FINAL,
    ST_DONE
  } pcse_state_e;

endpackage

// ===== hdl/pcse_ram.sv =====
module pcse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pcse_div.sv =====
module pcse_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pcse_pkg::pcse_div_req_t req_i,
  output pcse_pkg::pcse_div_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [pcse_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]                    num_q, num_d;
  logic [31:0]                    rem_q, rem_d;
  logic [31:0]                    den_q, den_d;
  logic                           neg_q, neg_d;

  logic [32:0] sh1, sh2;
  logic        ge1, ge2;
  logic [31:0] rem1;

  // Two restoring steps per cycle; the remainder stays below the divisor.
  assign sh1  = {rem_q, num_q[63]};
  assign ge1  = sh1 >= {1'b0, den_q};
  assign rem1 = ge1 ? 32'(sh1 - {1'b0, den_q}) : sh1[31:0];
  assign sh2  = {rem1, num_q[62]};
  assign ge2  = sh2 >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = req_i.dividend[63] ? 64'(-req_i.dividend) : 64'(req_i.dividend);
      den_d  = req_i.divisor[31] ? 32'(-req_i.divisor) : 32'(req_i.divisor);
      neg_d  = req_i.dividend[63] ^ req_i.divisor[31];
    end else if (busy_q) begin
      rem_d = ge2 ? 32'(sh2 - {1'b0, den_q}) : sh2[31:0];
      num_d = {num_q[61:0], ge1, ge2};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pcse_pkg::DIV_CNT_W'(pcse_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // The quotient magnitude is saturated to the signed 32-bit range.
  always_comb begin
    rsp_o.done = done_q;
    if (neg_q) begin
      if (num_q > 64'h8000_0000) begin
        rsp_o.quotient = pcse_pkg::Q_MIN;
      end else begin
        rsp_o.quotient = 32'(-num_q);
      end
    end else begin
      if (num_q > 64'h7FFF_FFFF) begin
        rsp_o.quotient = pcse_pkg::Q_MAX;
      end else begin
        rsp_o.quotient = num_q[31:0];
      end
    end
  end

endmodule

// ===== hdl/periodic_cubic_spline_eval_top.sv =====
// Periodic cubic spline evaluator, signed Q16.16.
// A load transfer gives no result. An evaluate transfer gives its result after its wrap steps
// and two 32-step divisions on the shared radix-4 divider. Faulted evaluations end early.
// The input stalls until the result is handed over; the next one can be taken the cycle after.
// Reset (asynchronous, active low) clears the sequencer and the output valid; the knot tables
// keep undefined contents until they are loaded.
module periodic_cubic_spline_eval_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pcse_pkg::pcse_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pcse_pkg::pcse_out_t  out_data_o
);

  localparam int unsigned IW = pcse_pkg::IDX_W;
  localparam int unsigned WW = pcse_pkg::WRAP_W;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // Clamp an exact intermediate to the Q16.16 range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > SAT_HI) begin
      return pcse_pkg::Q_MAX;
    end else if (v < SAT_LO) begin
      return pcse_pkg::Q_MIN;
    end
    return 32'(v);
  endfunction

  // Q16.16 product from the full 64-bit product, truncated toward zero.
  function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return sat32(66'(adj >>> 16));
  endfunction

  pcse_pkg::pcse_state_e state_q, state_d;

  // Sequencer working registers.
  logic signed [39:0] x_q, x_d;
  logic signed [31:0] first_q, first_d, last_q, last_d;
  logic [WW-1:0]      n_q, n_d;
  logic [IW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic signed [31:0] k0_q, k0_d, q0_q, q0_d, r0_q, r0_d;
  logic signed [31:0] k1_q, k1_d, q1_q, q1_d, r1_q, r1_d;
  logic signed [31:0] t_q, t_d, dx_q, dx_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] a_q, a_d, d_q, d_d, e_q, e_d, h_q, h_d;
  logic signed [31:0] res_q, res_d;
  logic               rflt_q, rflt_d, dflt_q, dflt_d;
  logic               out_valid_q, out_valid_d;
  pcse_pkg::pcse_out_t out_data_q, out_data_d;

  // Table ports.
  logic          accept;
  logic          load_ok;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic [31:0]   k_rd, q_rd, r_rd;
  logic signed [31:0] k_s, q_s, r_s;

  // Shared multiplier and divider.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  pcse_pkg::pcse_div_req_t div_req;
  pcse_pkg::pcse_div_rsp_t div_rsp;

  // Datapath terms.
  logic signed [32:0] span;
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic signed [31:0] s_diff, r0x3, c_val, f_val, qd_val, prodq, t_val, dx_val;
  logic signed [31:0] h_val, res_val;

  assign accept  = in_valid_i && !in_stall_o;
  assign load_ok = accept && (in_data_i.cmd == pcse_pkg::CMD_LOAD) &&
                   (32'(in_data_i.entry_index) <= 32'(pcse_pkg::INTERVALS));
  assign waddr   = IW'(in_data_i.entry_index);

  pcse_ram #(.WIDTH(32), .DEPTH(pcse_pkg::NKNOTS)) u_knot (
    .clk_i   (clk_i),
    .we_i    (load_ok && (in_data_i.table_select == pcse_pkg::TBL_KNOT)),
    .waddr_i (waddr),
    .wdata_i (in_data_i.value_in),
    .raddr_i (raddr),
    .rdata_o (k_rd)
  );

  pcse_ram #(.WIDTH(32), .DEPTH(pcse_pkg::NKNOTS)) u_node (
    .clk_i   (clk_i),
    .we_i    (load_ok && (in_data_i.table_select == pcse_pkg::TBL_NODE)),
    .waddr_i (waddr),
    .wdata_i (in_data_i.value_in),
    .raddr_i (raddr),
    .rdata_o (q_rd)
  );

  pcse_ram #(.WIDTH(32), .DEPTH(pcse_pkg::NKNOTS)) u_coef (
    .clk_i   (clk_i),
    .we_i    (load_ok && (in_data_i.table_select == pcse_pkg::TBL_COEF)),
    .waddr_i (waddr),
    .wdata_i (in_data_i.value_in),
    .raddr_i (raddr),
    .rdata_o (r_rd)
  );

  pcse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign k_s = $signed(k_rd);
  assign q_s = $signed(q_rd);
  assign r_s = $signed(r_rd);

  // The period is the distance from the first to the last knot.
  assign span    = 33'(first_q) * -1 + 33'(last_q);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];

  assign s_diff  = sat32(66'(r1_q) - 66'(r0_q));
  assign r0x3    = sat32(66'(r0_q) + 66'(r0_q) + 66'(r0_q));
  assign c_val   = sat32(66'(a_q) + 66'(r0x3));
  assign f_val   = sat32(66'(r0_q) + 66'(r0_q) + 66'(r1_q));
  assign qd_val  = sat32(66'(q1_q) - 66'(q0_q));
  assign prodq   = qmul(prod_q);
  assign t_val   = sat32(66'(x_q) - 66'(k0_q));
  assign dx_val  = sat32(66'(k1_q) - 66'(k0_q));
  assign h_val   = sat32(66'(d_q) + 66'(sat32(66'(e_q) - 66'(prodq))));
  assign res_val = sat32(66'(prodq) + 66'(q0_q));
  assign mul_p   = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    first_d     = first_q;
    last_d      = last_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k0_d        = k0_q;
    q0_d        = q0_q;
    r0_d        = r0_q;
    k1_d        = k1_q;
    q1_d        = q1_q;
    r1_d        = r1_q;
    t_d         = t_q;
    dx_d        = dx_q;
    prod_d      = prod_q;
    a_d         = a_q;
    d_d         = d_q;
    e_d         = e_q;
    h_d         = h_q;
    res_d       = res_q;
    rflt_d      = rflt_q;
    dflt_d      = dflt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    raddr       = '0;
    mul_a       = s_diff;
    mul_b       = t_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = dx_q;

    // The output register frees itself as soon as the result is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pcse_pkg::ST_IDLE: begin
        if (accept && (in_data_i.cmd == pcse_pkg::CMD_EVAL)) begin
          x_d     = 40'(in_data_i.value_in);
          res_d   = '0;
          rflt_d  = 1'b0;
          dflt_d  = 1'b0;
          state_d = pcse_pkg::ST_RD_FIRST;
        end
      end
      pcse_pkg::ST_RD_FIRST: begin
        raddr   = '0;
        state_d = pcse_pkg::ST_RD_LAST;
      end
      pcse_pkg::ST_RD_LAST: begin
        raddr   = IW'(pcse_pkg::INTERVALS);
        first_d = k_s;
        state_d = pcse_pkg::ST_GOT_LAST;
      end
      pcse_pkg::ST_GOT_LAST: begin
        last_d  = k_s;
        n_d     = '0;
        state_d = pcse_pkg::ST_WRAP_HI;
      end
      // Pull the point down by the period while it lies past the last knot.
      pcse_pkg::ST_WRAP_HI: begin
        if (x_q > 40'(last_q)) begin
          if (n_q >= WW'(pcse_pkg::MAX_WRAPS)) begin
            rflt_d  = 1'b1;
            state_d = pcse_pkg::ST_DONE;
          end else begin
            x_d = x_q - 40'(span);
            n_d = n_q + 1'b1;
          end
        end else begin
          n_d     = '0;
          state_d = pcse_pkg::ST_WRAP_LO;
        end
      end
      // Then raise it while it lies below the first knot.
      pcse_pkg::ST_WRAP_LO: begin
        if (x_q < 40'(first_q)) begin
          if (n_q >= WW'(pcse_pkg::MAX_WRAPS)) begin
            rflt_d  = 1'b1;
            state_d = pcse_pkg::ST_DONE;
          end else begin
            x_d = x_q + 40'(span);
            n_d = n_q + 1'b1;
          end
        end else begin
          lo_d    = '0;
          hi_d    = IW'(pcse_pkg::INTERVALS);
          state_d = pcse_pkg::ST_SRCH_RD;
        end
      end
      pcse_pkg::ST_SRCH_RD: begin
        raddr   = mid;
        state_d = pcse_pkg::ST_SRCH_CMP;
      end
      pcse_pkg::ST_SRCH_CMP: begin
        if (40'(k_s) < x_q) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        if (lo_d < hi_d) begin
          state_d = pcse_pkg::ST_SRCH_RD;
        end else begin
          state_d = pcse_pkg::ST_FIX;
        end
      end
      // Step back to the knot that opens the interval.
      pcse_pkg::ST_FIX: begin
        if (lo_q != '0) begin
          lo_d = lo_q - 1'b1;
        end
        if (lo_d > IW'(pcse_pkg::INTERVALS - 1)) begin
          lo_d = IW'(pcse_pkg::INTERVALS - 1);
        end
        state_d = pcse_pkg::ST_RD0;
      end
      pcse_pkg::ST_RD0: begin
        raddr   = lo_q;
        state_d = pcse_pkg::ST_RD1;
      end
      pcse_pkg::ST_RD1: begin
        raddr   = lo_q + 1'b1;
        k0_d    = k_s;
        q0_d    = q_s;
        r0_d    = r_s;
        state_d = pcse_pkg::ST_RD1_WAIT;
      end
      pcse_pkg::ST_RD1_WAIT: begin
        k1_d    = k_s;
        q1_d    = q_s;
        r1_d    = r_s;
        state_d = pcse_pkg::ST_TDX;
      end
      pcse_pkg::ST_TDX: begin
        t_d  = t_val;
        dx_d = dx_val;
        if (dx_val == '0) begin
          dflt_d  = 1'b1;
          state_d = pcse_pkg::ST_DONE;
        end else begin
          state_d = pcse_pkg::ST_MUL_S;
        end
      end
      pcse_pkg::ST_MUL_S: begin
        mul_a   = s_diff;
        mul_b   = t_q;
        prod_d  = mul_p;
        state_d = pcse_pkg::ST_DIV_A;
      end
      pcse_pkg::ST_DIV_A: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        state_d          = pcse_pkg::ST_WAIT_A;
      end
      pcse_pkg::ST_WAIT_A: begin
        if (div_rsp.done) begin
          a_d     = div_rsp.quotient;
          state_d = pcse_pkg::ST_MUL_C;
        end
      end
      pcse_pkg::ST_MUL_C: begin
        mul_a   = c_val;
        mul_b   = t_q;
        prod_d  = mul_p;
        state_d = pcse_pkg::ST_DIV_E;
      end
      pcse_pkg::ST_DIV_E: begin
        d_d              = prodq;
        div_req.start    = 1'b1;
        div_req.dividend = 64'(qd_val) <<< 16;
        state_d          = pcse_pkg::ST_WAIT_E;
      end
      pcse_pkg::ST_WAIT_E: begin
        if (div_rsp.done) begin
          e_d     = div_rsp.quotient;
          state_d = pcse_pkg::ST_MUL_G;
        end
      end
      pcse_pkg::ST_MUL_G: begin
        mul_a   = f_val;
        mul_b   = dx_q;
        prod_d  = mul_p;
        state_d = pcse_pkg::ST_CALC_H;
      end
      pcse_pkg::ST_CALC_H: begin
        h_d     = h_val;
        state_d = pcse_pkg::ST_MUL_H;
      end
      pcse_pkg::ST_MUL_H: begin
        mul_a   = h_q;
        mul_b   = t_q;
        prod_d  = mul_p;
        state_d = pcse_pkg::ST_FINAL;
      end
      pcse_pkg::ST_FINAL: begin
        res_d   = res_val;
        state_d = pcse_pkg::ST_DONE;
      end
      // Hand the result over once the output register is free.
      pcse_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_data_d.result_value = res_q;
          out_data_d.range_fault  = rflt_q;
          out_data_d.divide_fault = dflt_q;
          state_d                 = pcse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcse_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    first_q    <= first_d;
    last_q     <= last_d;
    n_q        <= n_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    k0_q       <= k0_d;
    q0_q       <= q0_d;
    r0_q       <= r0_d;
    k1_q       <= k1_d;
    q1_q       <= q1_d;
    r1_q       <= r1_d;
    t_q        <= t_d;
    dx_q       <= dx_d;
    prod_q     <= prod_d;
    a_q        <= a_d;
    d_q        <= d_d;
    e_q        <= e_d;
    h_q        <= h_d;
    res_q      <= res_d;
    rflt_q     <= rflt_d;
    dflt_q     <= dflt_d;
    out_data_q <= out_data_d;
  end

  // New items are taken only while the sequencer is idle.
  assign in_stall_o  = (state_q != pcse_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/pcse_checker.sv =====
module pcse_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pcse_pkg::pcse_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pcse_pkg::pcse_out_t out_data_o
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The two fault flags never come together.
  a_one_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.range_fault && out_data_o.divide_fault))
    else $error("both fault flags set");

  // A faulted result carries a zero value.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.range_fault || out_data_o.divide_fault)
      |-> out_data_o.result_value == '0)
    else $error("faulted result is not zero");

  // An evaluate transfer keeps the block busy in the next cycle.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.cmd == pcse_pkg::CMD_EVAL) |=> in_stall_o)
    else $error("block not busy after evaluate transfer");

endmodule

bind periodic_cubic_spline_eval_top pcse_checker u_pcse_checker (.*);
